[hw/rtl/crt_glow_pkg.sv]
// Shared constants, types and tables for the CRT phosphor glow filter.
package crt_glow_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int RADIUS     = 3;
    localparam int LINES      = 2 * RADIUS + 1;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int MOD_W      = $clog2(LINES);
    localparam int SIZE_W     = 11;
    localparam int ROW_W      = 11;
    localparam int LAG_W      = 22;
    localparam int STORE_DEPTH = LINES * MAX_WIDTH;
    localparam int ADDR_W     = MOD_W + COL_W;
    localparam int ENTRY_W    = 9;
    localparam int WT_W       = 12;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LIT_THRESHOLD  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PHOSPHOR_RED   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PHOSPHOR_GREEN = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_PHOSPHOR_BLUE  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SCANLINE_KEEP  = 3'd6;

    // weight by {|dy|, |dx|}
    localparam logic [WT_W-1:0] WEIGHT_TAB [16] = '{
        12'd2169, 12'd1737, 12'd892, 12'd294,
        12'd1737, 12'd1391, 12'd714, 12'd235,
        12'd892,  12'd714,  12'd367, 12'd121,
        12'd294,  12'd235,  12'd121, 12'd40
    };

    typedef struct packed {
        logic            valid;
        logic            center;
        logic            fin;
        logic [7:0]      b;
        logic [WT_W-1:0] wt;
    } tap_t;

endpackage

[hw/rtl/crt_glow_pix_if.sv]
// Pixel input channel.
interface crt_glow_pix_if;
    logic       valid;
    logic       ready;
    logic [7:0] pix_red;
    logic [7:0] pix_green;
    logic [7:0] pix_blue;
    logic       drain;

    modport source (output valid, pix_red, pix_green, pix_blue, drain, input ready);
    modport sink (input valid, pix_red, pix_green, pix_blue, drain, output ready);
endinterface

[hw/rtl/crt_glow_res_if.sv]
// Result pixel output channel.
interface crt_glow_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic       frame_end;

    modport source (output valid, out_red, out_green, out_blue, frame_end, input ready);
    modport sink (input valid, out_red, out_green, out_blue, frame_end, output ready);
endinterface

[hw/rtl/crt_glow_cfg_if.sv]
// Configuration write channel.
interface crt_glow_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [crt_glow_pkg::CFG_IDX_W-1:0]  index;
    logic [crt_glow_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

[hw/rtl/crt_glow_ram.sv]
// Generic simple dual-port RAM with registered read.
module crt_glow_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[hw/rtl/crt_glow_cell.sv]
// One color channel cell: accumulates glow taps and passes them on to the next cell.
module crt_glow_cell (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 clear,
    input  logic [7:0]           tint,
    input  logic [8:0]           keep,
    input  logic                 odd,
    input  crt_glow_pkg::tap_t   tap_in,
    output crt_glow_pkg::tap_t   tap_out,
    output logic [7:0]           res,
    output logic                 done
);

    logic                          s1_valid_reg, s1_fin_reg;
    logic [15:0]                   s1_p_reg;
    logic [crt_glow_pkg::WT_W-1:0] s1_wt_reg;
    logic                          s2_valid_reg, s2_fin_reg;
    logic [3:0]                    s2_term_reg;
    logic [9:0]                    acc_reg;
    logic                          cen_lit_reg;
    logic [15:0]                   cprod_reg;
    logic                          v_fin_reg;
    logic [7:0]                    v_reg;
    logic [27:0]                   prod;
    logic [7:0]                    g;
    logic [15:0]                   q_sum;
    logic [8:0]                    lit_sum;
    logic [7:0]                    v_next;
    logic [16:0]                   scaled;
    logic [7:0]                    res_next;

    assign prod    = {12'd0, s1_p_reg} * {16'd0, s1_wt_reg};
    assign g       = (acc_reg > 10'd255) ? 8'd255 : acc_reg[7:0];
    // floor(x/255) for x up to 255*255
    assign q_sum   = cprod_reg + {8'd0, cprod_reg[15:8]} + 16'd1;
    assign lit_sum = {1'b0, q_sum[15:8]} + {2'd0, g[7:1]};
    assign v_next  = cen_lit_reg ? (lit_sum[8] ? 8'd255 : lit_sum[7:0]) : g;
    assign scaled  = {9'd0, v_reg} * {8'd0, keep};
    assign res_next = odd ? ((scaled[16]) ? 8'd255 : scaled[15:8]) : v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_out      <= '0;
            s1_valid_reg <= 1'b0;
            s1_fin_reg   <= 1'b0;
            s2_valid_reg <= 1'b0;
            s2_fin_reg   <= 1'b0;
            acc_reg      <= '0;
            cen_lit_reg  <= 1'b0;
            v_fin_reg    <= 1'b0;
            done         <= 1'b0;
        end
        else
        begin
            tap_out      <= tap_in;
            s1_valid_reg <= tap_in.valid;
            s1_fin_reg   <= tap_in.fin;
            s2_valid_reg <= s1_valid_reg;
            s2_fin_reg   <= s1_fin_reg;
            v_fin_reg    <= s2_fin_reg;
            done         <= v_fin_reg;
            if (clear)
            begin
                acc_reg     <= '0;
                cen_lit_reg <= 1'b0;
            end
            else
            begin
                if (s2_valid_reg)
                begin
                    acc_reg <= acc_reg + {6'd0, s2_term_reg};
                end
                if (tap_in.center)
                begin
                    cen_lit_reg <= tap_in.valid;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        s1_p_reg    <= {8'd0, tint} * {8'd0, tap_in.b};
        s1_wt_reg   <= tap_in.wt;
        s2_term_reg <= prod[27:24];
        if (tap_in.center)
        begin
            cprod_reg <= {8'd0, tint} * {8'd0, tap_in.b};
        end
        if (s2_fin_reg)
        begin
            v_reg <= v_next;
        end
        if (v_fin_reg)
        begin
            res <= res_next;
        end
    end

endmodule

[hw/rtl/crt_phosphor_glow_filter.sv]
// Top level of the CRT phosphor glow filter.
//
// Pixels arrive on pix in raster order; results leave on res, one per emitting item.
// Configuration words on cfg write register "index" and are always taken at once.
// Each pixel's brightness and lit flag go into a seven-line store. Once the input has
// run three lines plus three pixels ahead of the output position, an accepted item
// starts a scan of the 7x7 neighborhood around the output pixel: one store read per
// cycle, through a chain of three channel cells (red, green, blue) that each weight
// and accumulate the taps and hand them on. An item that emits nothing leaves the
// block ready for the next item; an emitting item holds the input through its store
// reads on the single read port, the cell pipeline and the load of its result.
// After the frame's last pixel, drain items (or further pixels) flush the remaining
// results; the last one carries frame_end.
// Reset clears all positions and loads the register defaults; the line store needs no
// clearing. A stalled receiver holds the result register; the block still accepts
// the next item and scans it, and holds the new result until the register frees.
module crt_phosphor_glow_filter (
    input  logic            clk,
    input  logic            rst_n,
    crt_glow_cfg_if.sink    cfg,
    crt_glow_pix_if.sink    pix,
    crt_glow_res_if.source  res
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FIN,
        S_WAIT
    } state_t;

    typedef struct packed {
        logic                          slot;
        logic                          inframe;
        logic                          center;
        logic                          fin;
        logic [crt_glow_pkg::WT_W-1:0] wt;
    } issue_t;

    state_t state_reg;

    logic [crt_glow_pkg::SIZE_W-1:0] frame_width_reg, frame_height_reg;
    logic [7:0] lit_threshold_reg, phosphor_red_reg, phosphor_green_reg, phosphor_blue_reg;
    logic [8:0] scanline_keep_reg;

    logic [crt_glow_pkg::COL_W-1:0] in_col_reg, in_col_next, out_col_reg, out_col_next;
    logic [crt_glow_pkg::ROW_W-1:0] in_row_reg, in_row_next, out_row_reg, out_row_next;
    logic [crt_glow_pkg::MOD_W-1:0] in_mod_reg, in_mod_next, out_mod_reg, out_mod_next;
    logic signed [12:0]             drow;
    logic signed [25:0]             kdiff;

    logic [crt_glow_pkg::ROW_W-1:0] r_reg;
    logic [crt_glow_pkg::COL_W-1:0] c_reg;
    logic [crt_glow_pkg::MOD_W-1:0] nmod_reg;
    logic [2:0]                     dy_reg, dx_reg;
    logic                           fe_reg, fe_next;
    logic                           done_seen_reg;
    issue_t                         iss_reg, iss_next;

    logic       out_valid_reg;
    logic [7:0] out_red_reg, out_green_reg, out_blue_reg;
    logic       out_fe_reg;

    logic [crt_glow_pkg::SIZE_W-1:0] w_eff, h_eff;
    logic [12:0]                     thresh;
    logic                            clr, acc_in, emit, we;
    logic [7:0]                      br;
    logic [crt_glow_pkg::ENTRY_W-1:0] wdata, rdata;
    logic [crt_glow_pkg::ADDR_W-1:0]  waddr, raddr;
    logic [crt_glow_pkg::MOD_W:0]     start_mod;
    logic signed [12:0]               ny, nx;
    logic [1:0]                       ady, adx;
    logic                             out_free, load_out;

    crt_glow_pkg::tap_t taps [4];
    logic [7:0]         cell_res [3];
    logic               cell_done [3];
    logic [7:0]         tints [3];

    // ---- configuration
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg    <= 11'd1024;
            frame_height_reg   <= 11'd1024;
            lit_threshold_reg  <= 8'd30;
            phosphor_red_reg   <= 8'd51;
            phosphor_green_reg <= 8'd255;
            phosphor_blue_reg  <= 8'd51;
            scanline_keep_reg  <= 9'd218;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                crt_glow_pkg::CFG_FRAME_WIDTH:    frame_width_reg    <= cfg.data;
                crt_glow_pkg::CFG_FRAME_HEIGHT:   frame_height_reg   <= cfg.data;
                crt_glow_pkg::CFG_LIT_THRESHOLD:  lit_threshold_reg  <= cfg.data[7:0];
                crt_glow_pkg::CFG_PHOSPHOR_RED:   phosphor_red_reg   <= cfg.data[7:0];
                crt_glow_pkg::CFG_PHOSPHOR_GREEN: phosphor_green_reg <= cfg.data[7:0];
                crt_glow_pkg::CFG_PHOSPHOR_BLUE:  phosphor_blue_reg  <= cfg.data[7:0];
                crt_glow_pkg::CFG_SCANLINE_KEEP:  scanline_keep_reg  <= cfg.data[8:0];
                default: ;
            endcase
        end
    end

    assign w_eff = (frame_width_reg == '0) ? 11'd1 :
                   (frame_width_reg > 11'(crt_glow_pkg::MAX_WIDTH)) ?
                   11'(crt_glow_pkg::MAX_WIDTH) : frame_width_reg;
    assign h_eff = (frame_height_reg == '0) ? 11'd1 :
                   (frame_height_reg > 11'(crt_glow_pkg::MAX_HEIGHT)) ?
                   11'(crt_glow_pkg::MAX_HEIGHT) : frame_height_reg;
    assign thresh = {1'b0, w_eff, 1'b0} + {2'd0, w_eff} + 13'd3;

    // ---- input side
    assign pix.ready = (state_reg == S_IDLE);
    assign acc_in    = pix.valid && pix.ready;
    assign clr       = (out_row_reg >= h_eff);

    assign br = (pix.pix_red >= pix.pix_green && pix.pix_red >= pix.pix_blue) ? pix.pix_red :
                (pix.pix_green >= pix.pix_blue) ? pix.pix_green : pix.pix_blue;
    assign wdata = (br >= lit_threshold_reg) ? {1'b1, br} : '0;

    always_comb
    begin
        in_col_next  = clr ? '0 : in_col_reg;
        in_row_next  = clr ? '0 : in_row_reg;
        in_mod_next  = clr ? '0 : in_mod_reg;
        out_col_next = clr ? '0 : out_col_reg;
        out_row_next = clr ? '0 : out_row_reg;
        out_mod_next = clr ? '0 : out_mod_reg;
        // input raster index minus output raster index
        drow  = $signed({2'b00, in_row_next}) - $signed({2'b00, out_row_next});
        kdiff = drow * $signed({2'b00, w_eff})
                + $signed({16'd0, in_col_next}) - $signed({16'd0, out_col_next});
        waddr        = {in_mod_next, in_col_next};
        emit         = 1'b0;
        we           = 1'b0;
        fe_next      = 1'b0;
        if (in_row_next < h_eff)
        begin
            if (!pix.drain)
            begin
                we   = 1'b1;
                emit = (kdiff >= $signed({13'd0, thresh}));
                if ({1'b0, in_col_next} + 11'd1 >= w_eff)
                begin
                    in_col_next = '0;
                    in_row_next = in_row_next + 11'd1;
                    in_mod_next = (in_mod_next == 3'(crt_glow_pkg::LINES - 1)) ?
                                  '0 : in_mod_next + 3'd1;
                end
                else
                begin
                    in_col_next = in_col_next + 10'd1;
                end
            end
        end
        else
        begin
            emit = 1'b1;
        end
        if (emit)
        begin
            if ({1'b0, out_col_next} + 11'd1 >= w_eff)
            begin
                out_col_next = '0;
                out_row_next = out_row_next + 11'd1;
                out_mod_next = (out_mod_next == 3'(crt_glow_pkg::LINES - 1)) ?
                               '0 : out_mod_next + 3'd1;
            end
            else
            begin
                out_col_next = out_col_next + 10'd1;
            end
            if (out_row_next >= h_eff)
            begin
                fe_next      = 1'b1;
                in_col_next  = '0;
                in_row_next  = '0;
                in_mod_next  = '0;
                out_col_next = '0;
                out_row_next = '0;
                out_mod_next = '0;
            end
        end
    end

    // start row in the store: (out_mod - 3) mod 7
    assign start_mod = {1'b0, out_mod_reg} + 4'd4;

    // ---- neighborhood scan
    assign ny  = $signed({2'b00, r_reg}) + $signed({10'd0, dy_reg}) - 13'sd3;
    assign nx  = $signed({3'b000, c_reg}) + $signed({10'd0, dx_reg}) - 13'sd3;
    assign ady = (dy_reg >= 3'd3) ? 2'(dy_reg - 3'd3) : 2'(3'd3 - dy_reg);
    assign adx = (dx_reg >= 3'd3) ? 2'(dx_reg - 3'd3) : 2'(3'd3 - dx_reg);
    assign raddr = {nmod_reg, nx[crt_glow_pkg::COL_W-1:0]};

    always_comb
    begin
        iss_next.slot    = (state_reg == S_SCAN);
        iss_next.inframe = !ny[12] && (ny[11:0] < {1'b0, h_eff}) &&
                           !nx[12] && (nx[11:0] < {1'b0, w_eff});
        iss_next.center  = (dy_reg == 3'd3) && (dx_reg == 3'd3);
        iss_next.fin     = (state_reg == S_FIN);
        iss_next.wt      = crt_glow_pkg::WEIGHT_TAB[{ady, adx}];
    end

    crt_glow_ram #(
        .WIDTH (crt_glow_pkg::ENTRY_W),
        .DEPTH (crt_glow_pkg::STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (acc_in && we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_comb
    begin
        taps[0].valid  = iss_reg.slot && iss_reg.inframe && rdata[8];
        taps[0].center = iss_reg.slot && iss_reg.center;
        taps[0].fin    = iss_reg.fin;
        taps[0].b      = rdata[7:0];
        taps[0].wt     = iss_reg.wt;
    end

    assign tints[0] = phosphor_red_reg;
    assign tints[1] = phosphor_green_reg;
    assign tints[2] = phosphor_blue_reg;

    for (genvar i = 0; i < 3; i++)
    begin : g_cell
        crt_glow_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .clear   (acc_in && emit),
            .tint    (tints[i]),
            .keep    (scanline_keep_reg),
            .odd     (r_reg[0]),
            .tap_in  (taps[i]),
            .tap_out (taps[i+1]),
            .res     (cell_res[i]),
            .done    (cell_done[i])
        );
    end

    // ---- output register and control
    assign out_free = !out_valid_reg || res.ready;
    assign load_out = (state_reg == S_WAIT) && done_seen_reg && out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            in_col_reg    <= '0;
            in_row_reg    <= '0;
            in_mod_reg    <= '0;
            out_col_reg   <= '0;
            out_row_reg   <= '0;
            out_mod_reg   <= '0;
            dy_reg        <= '0;
            dx_reg        <= '0;
            nmod_reg      <= '0;
            done_seen_reg <= 1'b0;
            iss_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            iss_reg <= iss_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res.valid && res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (acc_in)
                    begin
                        in_col_reg  <= in_col_next;
                        in_row_reg  <= in_row_next;
                        in_mod_reg  <= in_mod_next;
                        out_col_reg <= out_col_next;
                        out_row_reg <= out_row_next;
                        out_mod_reg <= out_mod_next;
                        if (emit)
                        begin
                            state_reg     <= S_SCAN;
                            dy_reg        <= '0;
                            dx_reg        <= '0;
                            done_seen_reg <= 1'b0;
                            nmod_reg      <= clr ? 3'd4 :
                                             (start_mod >= 4'(crt_glow_pkg::LINES)) ?
                                             3'(start_mod - 4'(crt_glow_pkg::LINES)) :
                                             start_mod[2:0];
                        end
                    end
                end
                S_SCAN:
                begin
                    if (dx_reg == 3'd6)
                    begin
                        dx_reg   <= '0;
                        dy_reg   <= dy_reg + 3'd1;
                        nmod_reg <= (nmod_reg == 3'(crt_glow_pkg::LINES - 1)) ?
                                    '0 : nmod_reg + 3'd1;
                        if (dy_reg == 3'd6)
                        begin
                            state_reg <= S_FIN;
                        end
                    end
                    else
                    begin
                        dx_reg <= dx_reg + 3'd1;
                    end
                end
                S_FIN:
                begin
                    state_reg <= S_WAIT;
                end
                S_WAIT:
                begin
                    if (cell_done[2])
                    begin
                        done_seen_reg <= 1'b1;
                    end
                    if (load_out)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc_in && emit)
        begin
            r_reg  <= clr ? '0 : out_row_reg;
            c_reg  <= clr ? '0 : out_col_reg;
            fe_reg <= fe_next;
        end
        if (load_out)
        begin
            out_red_reg   <= cell_res[0];
            out_green_reg <= cell_res[1];
            out_blue_reg  <= cell_res[2];
            out_fe_reg    <= fe_reg;
        end
    end

    assign res.valid     = out_valid_reg;
    assign res.out_red   = out_red_reg;
    assign res.out_green = out_green_reg;
    assign res.out_blue  = out_blue_reg;
    assign res.frame_end = out_fe_reg;

    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        cell_done[2] |-> state_reg == S_WAIT)
        else $error("cell chain finished outside wait");

    a_scan_flow: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SCAN |=> state_reg == S_SCAN || state_reg == S_FIN)
        else $error("scan left early");

    a_load_frees: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |=> res.valid && state_reg == S_IDLE)
        else $error("result not presented after load");

endmodule

[verif/crt_phosphor_glow_filter_tb.sv]
// Testbench for the CRT phosphor glow filter: drives frames and checks each word.
module crt_phosphor_glow_filter_tb;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int ITEM_TARGET = 1850;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       fe;
    } glow_px_t;

    typedef struct {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       drain;
        bit         typed;
        glow_px_t   want;
    } stim_row_t;

    logic clk;
    logic rst_n;
    crt_glow_cfg_if cfg ();
    crt_glow_pix_if pix ();
    crt_glow_res_if res ();

    crt_phosphor_glow_filter u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg.sink),
        .pix   (pix.sink),
        .res   (res.source)
    );

    int gauss_wt [4][4] = '{
        '{2169, 1737, 892, 294},
        '{1737, 1391, 714, 235},
        '{892, 714, 367, 121},
        '{294, 235, 121, 40}
    };

    logic [8:0] brite_store [crt_glow_pkg::LINES*crt_glow_pkg::MAX_WIDTH];
    int in_c, in_r, out_c, out_r;
    int cf_width, cf_height, cf_thresh, cf_keep;
    int cf_tint [3];

    glow_px_t expected_px [$];
    int errors;
    int cycles;
    int items;
    bit burst;
    bit hold_req;

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d want %0d at cycle %0d", what, got, want, cycles);
        errors++;
    endtask

    function automatic int clamp_dim(int v);
        if (v < 1)
            return 1;
        if (v > crt_glow_pkg::MAX_WIDTH)
            return crt_glow_pkg::MAX_WIDTH;
        return v;
    endfunction

    function automatic logic [8:0] store_rd(int row, int col);
        if (col >= crt_glow_pkg::MAX_WIDTH)
            return 9'd0;
        return brite_store[(row % crt_glow_pkg::LINES) * crt_glow_pkg::MAX_WIDTH + col];
    endfunction

    function automatic glow_px_t shade_pixel(int r, int c, int w, int h);
        int glow [3];
        int v;
        int g;
        int wt;
        int ny;
        int nx;
        logic [8:0] e;
        glow_px_t px;
        glow = '{0, 0, 0};
        for (int dy = -crt_glow_pkg::RADIUS; dy <= crt_glow_pkg::RADIUS; dy++)
        begin
            ny = r + dy;
            if (ny < 0 || ny >= h)
                continue;
            for (int dx = -crt_glow_pkg::RADIUS; dx <= crt_glow_pkg::RADIUS; dx++)
            begin
                nx = c + dx;
                if (nx < 0 || nx >= w)
                    continue;
                e = store_rd(ny, nx);
                if (!e[8])
                    continue;
                wt = gauss_wt[dy < 0 ? -dy : dy][dx < 0 ? -dx : dx];
                for (int ch = 0; ch < 3; ch++)
                    glow[ch] += (cf_tint[ch] * int'(e[7:0]) * wt) >>> 24;
            end
        end
        e = store_rd(r, c);
        for (int ch = 0; ch < 3; ch++)
        begin
            g = glow[ch] > 255 ? 255 : glow[ch];
            v = g;
            if (e[8])
            begin
                v = cf_tint[ch] * int'(e[7:0]) / 255 + g / 2;
                if (v > 255)
                    v = 255;
            end
            if (r % 2 == 1)
            begin
                v = (v * cf_keep) >>> 8;
                if (v > 255)
                    v = 255;
            end
            case (ch)
                0: px.red = v[7:0];
                1: px.green = v[7:0];
                default: px.blue = v[7:0];
            endcase
        end
        px.fe = 1'b0;
        return px;
    endfunction

    function automatic glow_px_t emit_px(int w, int h);
        glow_px_t px;
        px = shade_pixel(out_r, out_c, w, h);
        out_c++;
        if (out_c >= w)
        begin
            out_c = 0;
            out_r++;
        end
        if (out_r >= h)
        begin
            px.fe = 1'b1;
            in_c = 0; in_r = 0; out_c = 0; out_r = 0;
        end
        return px;
    endfunction

    // returns 1 when the item produces a word
    function automatic bit glow_step(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic dr,
                                     output glow_px_t px);
        int w;
        int h;
        int br;
        longint k;
        longint o;
        w = clamp_dim(cf_width);
        h = clamp_dim(cf_height);
        px = '0;
        if (out_r >= h)
        begin
            in_c = 0; in_r = 0; out_c = 0; out_r = 0;
        end
        if (in_r < h)
        begin
            if (dr)
                return 0;
            br = r;
            if (g > br)
                br = g;
            if (b > br)
                br = b;
            if (in_c < crt_glow_pkg::MAX_WIDTH)
                brite_store[(in_r % crt_glow_pkg::LINES) * crt_glow_pkg::MAX_WIDTH + in_c] =
                    br >= cf_thresh ? {1'b1, br[7:0]} : 9'd0;
            k = longint'(in_r) * w + in_c;
            o = longint'(out_r) * w + out_c;
            in_c++;
            if (in_c >= w)
            begin
                in_c = 0;
                in_r++;
            end
            if (k >= o + crt_glow_pkg::RADIUS * w + crt_glow_pkg::RADIUS)
            begin
                px = emit_px(w, h);
                return 1;
            end
            return 0;
        end
        px = emit_px(w, h);
        return 1;
    endfunction

    task automatic write_reg(logic [crt_glow_pkg::CFG_IDX_W-1:0] idx, int val);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= val[crt_glow_pkg::CFG_DATA_W-1:0];
        do
            @(posedge clk);
        while (!cfg.ready);
        cfg.valid <= 1'b0;
        @(posedge clk);
        case (idx)
            crt_glow_pkg::CFG_FRAME_WIDTH:    cf_width = val & 'h7FF;
            crt_glow_pkg::CFG_FRAME_HEIGHT:   cf_height = val & 'h7FF;
            crt_glow_pkg::CFG_LIT_THRESHOLD:  cf_thresh = val & 'hFF;
            crt_glow_pkg::CFG_PHOSPHOR_RED:   cf_tint[0] = val & 'hFF;
            crt_glow_pkg::CFG_PHOSPHOR_GREEN: cf_tint[1] = val & 'hFF;
            crt_glow_pkg::CFG_PHOSPHOR_BLUE:  cf_tint[2] = val & 'hFF;
            crt_glow_pkg::CFG_SCANLINE_KEEP:  cf_keep = val & 'h1FF;
            default: ;
        endcase
    endtask

    task automatic wait_idle();
        pix.valid <= 1'b0;
        wait (expected_px.size() == 0);
        repeat (100) @(posedge clk);
    endtask

    task automatic set_all(int w, int h, int thr, int tr, int tg, int tb, int keep);
        wait_idle();
        write_reg(crt_glow_pkg::CFG_FRAME_WIDTH, w);
        write_reg(crt_glow_pkg::CFG_FRAME_HEIGHT, h);
        write_reg(crt_glow_pkg::CFG_LIT_THRESHOLD, thr);
        write_reg(crt_glow_pkg::CFG_PHOSPHOR_RED, tr);
        write_reg(crt_glow_pkg::CFG_PHOSPHOR_GREEN, tg);
        write_reg(crt_glow_pkg::CFG_PHOSPHOR_BLUE, tb);
        write_reg(crt_glow_pkg::CFG_SCANLINE_KEEP, keep);
    endtask

    // returns 1 if a word is expected from this item
    task automatic send_item(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic dr,
                             output bit made);
        int gap;
        glow_px_t px;
        gap = burst ? 0 : $urandom_range(0, 6);
        if (gap > 0)
        begin
            pix.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pix.valid     <= 1'b1;
        pix.pix_red   <= r;
        pix.pix_green <= g;
        pix.pix_blue  <= b;
        pix.drain     <= dr;
        do
            @(posedge clk);
        while (!pix.ready);
        items++;
        made = glow_step(r, g, b, dr, px);
        if (made)
            expected_px.push_back(px);
    endtask

    function automatic logic [7:0] rand_chan();
        case ($urandom_range(0, 3))
            0: return 8'd0;
            1: return 8'd255;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic run_frame();
        int w;
        int h;
        bit made;
        w = clamp_dim(cf_width);
        h = clamp_dim(cf_height);
        for (int i = 0; i < w * h; i++)
        begin
            if ($urandom_range(0, 19) == 0)
                send_item(rand_chan(), rand_chan(), rand_chan(), 1'b1, made);
            send_item(rand_chan(), rand_chan(), rand_chan(), 1'b0, made);
        end
        while (in_r >= h)
        begin
            if ($urandom_range(0, 3) == 0)
                send_item(rand_chan(), rand_chan(), rand_chan(), 1'b0, made);
            else
                send_item(8'd0, 8'd0, 8'd0, 1'b1, made);
        end
    endtask

    always @(posedge clk)
    begin
        glow_px_t want;
        if (rst_n && res.valid && res.ready)
        begin
            if (expected_px.size() == 0)
                report_mismatch("unexpected word", 1, 0);
            else
            begin
                want = expected_px.pop_front();
                if (res.out_red !== want.red)
                    report_mismatch("out_red", res.out_red, want.red);
                if (res.out_green !== want.green)
                    report_mismatch("out_green", res.out_green, want.green);
                if (res.out_blue !== want.blue)
                    report_mismatch("out_blue", res.out_blue, want.blue);
                if (res.frame_end !== want.fe)
                    report_mismatch("frame_end", res.frame_end, want.fe);
            end
        end
    end

    initial
    begin
        int n;
        res.ready <= 1'b0;
        wait (rst_n);
        forever
        begin
            if (hold_req)
            begin
                hold_req = 1'b0;
                res.ready <= 1'b0;
                repeat (400) @(posedge clk);
            end
            n = burst ? 0 : $urandom_range(0, 6);
            if (n > 0)
            begin
                res.ready <= 1'b0;
                repeat (n) @(posedge clk);
            end
            res.ready <= 1'b1;
            do
                @(posedge clk);
            while (!res.valid);
        end
    end

    stim_row_t dir_tab [11] = '{
        '{8'd255, 8'd255, 8'd255, 1'b0, 1'b0, '0},
        '{8'd0, 8'd0, 8'd0, 1'b1, 1'b1, '{8'd51, 8'd255, 8'd51, 1'b1}},
        '{8'd0, 8'd0, 8'd0, 1'b0, 1'b0, '0},
        '{8'd0, 8'd0, 8'd0, 1'b1, 1'b1, '{8'd0, 8'd0, 8'd0, 1'b1}},
        '{8'd0, 8'd0, 8'd0, 1'b1, 1'b0, '0},
        '{8'd29, 8'd0, 8'd0, 1'b0, 1'b0, '0},
        '{8'd0, 8'd0, 8'd0, 1'b1, 1'b1, '{8'd0, 8'd0, 8'd0, 1'b1}},
        '{8'd0, 8'd30, 8'd0, 1'b0, 1'b0, '0},
        '{8'd0, 8'd0, 8'd0, 1'b1, 1'b1, '{8'd6, 8'd30, 8'd6, 1'b1}},
        '{8'd0, 8'd0, 8'd255, 1'b0, 1'b0, '0},
        '{8'd200, 8'd100, 8'd0, 1'b0, 1'b1, '{8'd51, 8'd255, 8'd51, 1'b1}}
    };

    initial
    begin
        bit made;
        int phase;
        clk = 1'b0;
        rst_n = 1'b0;
        cycles = 0;
        errors = 0;
        items = 0;
        burst = 1'b0;
        hold_req = 1'b0;
        in_c = 0; in_r = 0; out_c = 0; out_r = 0;
        cf_width = 1024; cf_height = 1024; cf_thresh = 30; cf_keep = 218;
        cf_tint = '{51, 255, 51};
        cfg.valid <= 1'b0;
        cfg.index <= crt_glow_pkg::CFG_FRAME_WIDTH;
        cfg.data  <= '0;
        pix.valid <= 1'b0;
        pix.pix_red <= '0;
        pix.pix_green <= '0;
        pix.pix_blue <= '0;
        pix.drain <= 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_reg(crt_glow_pkg::CFG_FRAME_WIDTH, 1);
        write_reg(crt_glow_pkg::CFG_FRAME_HEIGHT, 1);
        foreach (dir_tab[i])
        begin
            send_item(dir_tab[i].red, dir_tab[i].green, dir_tab[i].blue, dir_tab[i].drain, made);
            if (made && dir_tab[i].typed)
                expected_px[$] = dir_tab[i].want;
        end

        // extremes: size clamps, threshold, tint and scale saturation
        set_all(0, 2047, 0, 255, 255, 255, 511);
        burst = 1'b1;
        run_frame();
        burst = 1'b0;
        set_all(7, 6, 255, 0, 0, 0, 0);
        run_frame();
        set_all(5, 9, 128, 255, 0, 255, 256);
        hold_req = 1'b1;
        run_frame();
        set_all(1024, 1, 30, 51, 255, 51, 218);
        set_all(4, 4, 30, 51, 255, 51, 218);
        run_frame();

        phase = 0;
        while (items < ITEM_TARGET)
        begin
            set_all($urandom_range(1, 12), $urandom_range(1, 10), $urandom_range(0, 255),
                    rand_chan(), rand_chan(), rand_chan(), $urandom_range(0, 300));
            burst = (phase % 5 == 3);
            repeat ($urandom_range(1, 3)) run_frame();
            phase++;
        end
        burst = 1'b0;
        pix.valid <= 1'b0;

        wait (expected_px.size() == 0);
        repeat (150) @(posedge clk);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
